// ===== sv/assert_macros.svh =====
// Assertion helpers shared by the texture load hazard tracker RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a property holds at every rising clock edge outside reset.
`define THLT_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Checks that a condition never holds outside reset.
`define THLT_NEVER(label, clk, rstn, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

`endif

// ===== sv/thlt_pkg.sv =====
// ----------------------------------------------------------------------------
// thlt_pkg
// Shared types and command codes of the texture load hazard tracker.
// ----------------------------------------------------------------------------
package thlt_pkg;

    // Command codes, carried in bits 5..0 of s_tdata (cmd_code).
    localparam logic [5:0] CMD_SET_COLOR     = 6'h3f;
    localparam logic [5:0] CMD_SET_DEPTH     = 6'h3e;
    localparam logic [5:0] CMD_SET_TEXTURE   = 6'h3d;
    localparam logic [5:0] CMD_SET_SCISSOR   = 6'h2d;
    localparam logic [5:0] CMD_DRAW_FIRST    = 6'h08;
    localparam logic [5:0] CMD_DRAW_LAST     = 6'h0f;
    localparam logic [5:0] CMD_TEX_RECT      = 6'h24;
    localparam logic [5:0] CMD_TEX_RECT_FLIP = 6'h25;
    localparam logic [5:0] CMD_FILL_RECT     = 6'h36;
    localparam logic [5:0] CMD_LOAD_BLOCK    = 6'h33;
    localparam logic [5:0] CMD_LOAD_TILE     = 6'h34;
    localparam logic [5:0] CMD_LOAD_TLUT     = 6'h30;

    localparam logic [10:0] SCISSOR_ROWS_RESET = 11'd240;

    // What the back end has to do with a queued word.
    localparam logic [1:0] KIND_NONE  = 2'd0;
    localparam logic [1:0] KIND_DRAW  = 2'd1;
    localparam logic [1:0] KIND_LOAD  = 2'd2;
    localparam logic [1:0] KIND_FLUSH = 2'd3;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;
    localparam int QUEUE_CW    = 3;

    // Byte ranges of one command. For a draw, range 0 is color and range 1
    // is depth; for a load only range 0 is used.
    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] lo0;
        logic [31:0] hi0;
        logic [31:0] lo1;
        logic [31:0] hi1;
    } range_entry_t;

endpackage

// ===== sv/thlt_front.sv =====
// ----------------------------------------------------------------------------
// thlt_front
// Decodes commands, keeps the image shadow and computes the byte ranges.
// ----------------------------------------------------------------------------
module thlt_front import thlt_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         in_valid,
    output logic         in_ready,
    input  logic         req_type,
    input  logic [5:0]   cmd_code,
    input  logic [31:0]  word0,
    input  logic [31:0]  word1,
    output logic         q_wr_valid,
    input  logic         q_wr_ready,
    output range_entry_t q_wr_data
);

    function automatic logic [31:0] pix_bytes(input logic [23:0] pix, input logic [1:0] size);
        logic [26:0] shifted;
        shifted = {3'b000, pix} << size;
        return {6'b000000, shifted[26:1]};
    endfunction

    logic [23:0] color_base_reg;
    logic [10:0] color_width_reg;
    logic [1:0]  color_psize_reg;
    logic [23:0] depth_base_reg;
    logic [23:0] tex_base_reg;
    logic [10:0] tex_width_reg;
    logic [1:0]  tex_psize_reg;
    logic [10:0] scissor_rows_reg;

    logic        a_valid_reg, a_valid_next;
    logic [1:0]  a_kind_reg, a_kind_next;
    logic [1:0]  a_psize_reg, a_psize_next;
    logic [23:0] a_base_reg, a_base_next;
    logic [23:0] a_depth_reg;
    logic [22:0] a_prod_a_reg, a_prod_a_next;
    logic [22:0] a_prod_b_reg, a_prod_b_next;
    logic [12:0] a_off_lo_reg, a_off_lo_next;
    logic [12:0] a_off_hi_reg, a_off_hi_next;

    logic        accept;
    logic        is_block;
    logic [10:0] mul_x;
    logic [11:0] mul_ya, mul_yb;

    assign in_ready = !a_valid_reg || q_wr_ready;
    assign accept   = in_valid && in_ready;

    always_comb begin
        a_kind_next = KIND_NONE;
        is_block    = 1'b0;
        case (cmd_code) inside
            [CMD_DRAW_FIRST:CMD_DRAW_LAST], CMD_TEX_RECT, CMD_TEX_RECT_FLIP,
            CMD_FILL_RECT: begin
                a_kind_next = KIND_DRAW;
            end
            CMD_LOAD_BLOCK: begin
                a_kind_next = KIND_LOAD;
                is_block    = 1'b1;
            end
            CMD_LOAD_TILE, CMD_LOAD_TLUT: begin
                a_kind_next = KIND_LOAD;
            end
            default: begin
                a_kind_next = KIND_NONE;
            end
        endcase
        if (req_type) begin
            a_kind_next = KIND_FLUSH;
        end
    end

    // A draw multiplies width by scissor rows; a load multiplies the texture
    // width by its first and last row (a block uses one row for both ends).
    always_comb begin
        if (a_kind_next == KIND_DRAW) begin
            mul_x  = color_width_reg;
            mul_ya = {1'b0, scissor_rows_reg};
            mul_yb = {1'b0, scissor_rows_reg};
        end else if (is_block) begin
            mul_x  = tex_width_reg;
            mul_ya = word0[11:0];
            mul_yb = word0[11:0];
        end else begin
            mul_x  = tex_width_reg;
            mul_ya = {2'b00, word0[11:2]};
            mul_yb = {2'b00, word1[11:2]} + 12'd1;
        end
        a_prod_a_next = {12'd0, mul_x} * {11'd0, mul_ya};
        a_prod_b_next = {12'd0, mul_x} * {11'd0, mul_yb};
        a_off_lo_next = is_block ? {1'b0, word0[23:12]} : 13'd0;
        a_off_hi_next = is_block ? ({1'b0, word1[23:12]} + 13'd1) : 13'd0;
        a_psize_next  = (a_kind_next == KIND_DRAW) ? color_psize_reg : tex_psize_reg;
        a_base_next   = (a_kind_next == KIND_DRAW) ? color_base_reg : tex_base_reg;
        a_valid_next  = accept ? 1'b1 : (q_wr_ready ? 1'b0 : a_valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            color_base_reg   <= '0;
            color_width_reg  <= '0;
            color_psize_reg  <= '0;
            depth_base_reg   <= '0;
            tex_base_reg     <= '0;
            tex_width_reg    <= '0;
            tex_psize_reg    <= '0;
            scissor_rows_reg <= SCISSOR_ROWS_RESET;
        end else if (accept && !req_type) begin
            case (cmd_code)
                CMD_SET_COLOR: begin
                    color_psize_reg <= word0[20:19];
                    color_width_reg <= {1'b0, word0[9:0]} + 11'd1;
                    color_base_reg  <= word1[23:0];
                end
                CMD_SET_DEPTH: begin
                    depth_base_reg <= word1[23:0];
                end
                CMD_SET_TEXTURE: begin
                    tex_psize_reg <= word0[20:19];
                    tex_width_reg <= {1'b0, word0[9:0]} + 11'd1;
                    tex_base_reg  <= word1[23:0];
                end
                CMD_SET_SCISSOR: begin
                    scissor_rows_reg <= {1'b0, word1[11:2]} + 11'd1;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else begin
            a_valid_reg <= a_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            a_kind_reg   <= a_kind_next;
            a_psize_reg  <= a_psize_next;
            a_base_reg   <= a_base_next;
            a_depth_reg  <= depth_base_reg;
            a_prod_a_reg <= a_prod_a_next;
            a_prod_b_reg <= a_prod_b_next;
            a_off_lo_reg <= a_off_lo_next;
            a_off_hi_reg <= a_off_hi_next;
        end
    end

    // Second step: turn pixel counts into byte addresses.
    logic [23:0] pix_lo, pix_hi;
    logic [31:0] base32, depth32;

    always_comb begin
        pix_lo  = {1'b0, a_prod_a_reg} + {11'd0, a_off_lo_reg};
        pix_hi  = {1'b0, a_prod_b_reg} + {11'd0, a_off_hi_reg};
        base32  = {8'd0, a_base_reg};
        depth32 = {8'd0, a_depth_reg};
        q_wr_data.kind = a_kind_reg;
        if (a_kind_reg == KIND_DRAW) begin
            q_wr_data.lo0 = base32;
            q_wr_data.hi0 = base32 + pix_bytes({1'b0, a_prod_a_reg}, a_psize_reg);
            q_wr_data.lo1 = depth32;
            q_wr_data.hi1 = depth32 + {8'd0, a_prod_a_reg, 1'b0};
        end else begin
            q_wr_data.lo0 = base32 + pix_bytes(pix_lo, a_psize_reg);
            q_wr_data.hi0 = base32 + pix_bytes(pix_hi, a_psize_reg) + 32'd8;
            q_wr_data.lo1 = q_wr_data.lo0;
            q_wr_data.hi1 = q_wr_data.hi0;
        end
    end

    assign q_wr_valid = a_valid_reg;

    `include "assert_macros.svh"

    `THLT_ASSERT(a_hold_on_stall, aclk, aresetn, a_valid_reg && !q_wr_ready |=> a_valid_reg && $stable(a_kind_reg) && $stable(a_prod_a_reg), "front stage lost a stalled command")
    `THLT_NEVER(scissor_zero, aclk, aresetn, scissor_rows_reg == 11'd0, "scissor row count is zero")

endmodule

// ===== sv/thlt_queue.sv =====
// ----------------------------------------------------------------------------
// thlt_queue
// Short queue of computed ranges between the front and the back end.
// ----------------------------------------------------------------------------
module thlt_queue import thlt_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         wr_valid,
    output logic         wr_ready,
    input  range_entry_t wr_data,
    output logic         rd_valid,
    input  logic         rd_ready,
    output range_entry_t rd_data
);

    range_entry_t mem [QUEUE_DEPTH];

    logic [QUEUE_AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QUEUE_CW-1:0] count_reg, count_next;
    logic                push, pop;

    assign wr_ready = (count_reg != QUEUE_CW'(QUEUE_DEPTH));
    assign rd_valid = (count_reg != '0);
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;
    assign rd_data  = mem[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + QUEUE_CW'(1);
        end else if (pop && !push) begin
            count_next = count_reg - QUEUE_CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + QUEUE_AW'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + QUEUE_AW'(1);
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

    `include "assert_macros.svh"

    `THLT_NEVER(count_over, aclk, aresetn, count_reg > QUEUE_CW'(QUEUE_DEPTH), "queue count above depth")
    `THLT_ASSERT(count_step, aclk, aresetn, push && !pop |=> count_reg == $past(count_reg) + QUEUE_CW'(1), "queue count did not follow a push")

endmodule

// ===== sv/thlt_back.sv =====
// ----------------------------------------------------------------------------
// thlt_back
// Keeps the pending draw and load ranges, widens them and flags overlaps.
// ----------------------------------------------------------------------------
module thlt_back import thlt_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         q_rd_valid,
    output logic         q_rd_ready,
    input  range_entry_t q_rd_data,
    output logic         out_valid,
    input  logic         out_ready,
    output logic         out_wait
);

    logic [31:0] pend_lo_reg [2];
    logic [31:0] pend_hi_reg [2];
    logic [1:0]  pend_valid_reg;
    logic [31:0] load_lo_reg, load_hi_reg;
    logic        load_valid_reg;
    logic        out_valid_reg, out_wait_reg;

    logic        pop;
    logic        wait_next;
    logic [31:0] rlo [2];
    logic [31:0] rhi [2];

    assign q_rd_ready = !out_valid_reg || out_ready;
    assign pop        = q_rd_valid && q_rd_ready;
    assign rlo[0]     = q_rd_data.lo0;
    assign rhi[0]     = q_rd_data.hi0;
    assign rlo[1]     = q_rd_data.lo1;
    assign rhi[1]     = q_rd_data.hi1;

    always_comb begin
        wait_next = 1'b0;
        case (q_rd_data.kind)
            KIND_DRAW: begin
                for (int k = 0; k < 2; k++) begin
                    if (load_valid_reg && rlo[k] < load_hi_reg && rhi[k] > load_lo_reg) begin
                        wait_next = 1'b1;
                    end
                end
            end
            KIND_LOAD: begin
                for (int k = 0; k < 2; k++) begin
                    if (pend_valid_reg[k] && rlo[0] < pend_hi_reg[k]
                        && rhi[0] > pend_lo_reg[k]) begin
                        wait_next = 1'b1;
                    end
                end
            end
            default: begin
                wait_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_valid_reg <= '0;
            load_valid_reg <= 1'b0;
        end else if (pop) begin
            case (q_rd_data.kind)
                KIND_DRAW: begin
                    pend_valid_reg <= 2'b11;
                end
                KIND_LOAD: begin
                    load_valid_reg <= 1'b1;
                end
                KIND_FLUSH: begin
                    pend_valid_reg <= '0;
                    load_valid_reg <= 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    // An empty tracker takes the new range as it is.
    always_ff @(posedge aclk) begin
        if (pop && q_rd_data.kind == KIND_DRAW) begin
            for (int k = 0; k < 2; k++) begin
                if (!pend_valid_reg[k] || rlo[k] < pend_lo_reg[k]) begin
                    pend_lo_reg[k] <= rlo[k];
                end
                if (!pend_valid_reg[k] || rhi[k] > pend_hi_reg[k]) begin
                    pend_hi_reg[k] <= rhi[k];
                end
            end
        end
        if (pop && q_rd_data.kind == KIND_LOAD) begin
            if (!load_valid_reg || rlo[0] < load_lo_reg) begin
                load_lo_reg <= rlo[0];
            end
            if (!load_valid_reg || rhi[0] > load_hi_reg) begin
                load_hi_reg <= rhi[0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (pop) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            out_wait_reg <= wait_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_wait  = out_wait_reg;

    `include "assert_macros.svh"

    `THLT_ASSERT(flush_clears, aclk, aresetn, pop && q_rd_data.kind == KIND_FLUSH |=> pend_valid_reg == 2'b00 && !load_valid_reg, "flush left a range marked valid")
    `THLT_ASSERT(load_idle_no_wait, aclk, aresetn, pop && q_rd_data.kind == KIND_LOAD && pend_valid_reg == 2'b00 |=> !out_wait_reg, "load waited with no pending draw")

endmodule

// ===== sv/texture_load_hazard_tracker.sv =====
// ----------------------------------------------------------------------------
// texture_load_hazard_tracker
// Flags graphics commands that conflict with buffered draws or texture loads.
// ----------------------------------------------------------------------------
// The slave channel takes one word per command: a command code with its two
// command words, or a flush marker in s_tuser that clears every tracked range.
// The master channel returns one word per accepted input, in order, whose
// bit 0 is set when the command overlaps buffered work and has to wait.
// A word's result passes through the front stage register, the queue and the
// output register before m_tvalid shows it. The block takes one word every
// cycle while the receiver keeps up: the front end multiplies in one step and
// forms byte ranges in the next, a four-entry queue follows, and the back end
// compares and widens the ranges into the output register.
// Reset clears all ranges and sets the image shadow to its default, with 240
// scissor rows. When m_tready is low the output register holds its word, the
// queue fills, and s_tready drops once the queue and front stage are full.
// ----------------------------------------------------------------------------
module texture_load_hazard_tracker import thlt_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // cmd_code[5:0], word0[37:6], word1[69:38], zero pad
    input  logic        s_tuser,   // req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata    // must_wait[0], zero pad
);

    logic         q_wr_valid, q_wr_ready;
    range_entry_t q_wr_data;
    logic         q_rd_valid, q_rd_ready;
    range_entry_t q_rd_data;
    logic         must_wait;

    thlt_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .req_type   (s_tuser),
        .cmd_code   (s_tdata[5:0]),
        .word0      (s_tdata[37:6]),
        .word1      (s_tdata[69:38]),
        .q_wr_valid (q_wr_valid),
        .q_wr_ready (q_wr_ready),
        .q_wr_data  (q_wr_data)
    );

    thlt_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (q_wr_valid),
        .wr_ready (q_wr_ready),
        .wr_data  (q_wr_data),
        .rd_valid (q_rd_valid),
        .rd_ready (q_rd_ready),
        .rd_data  (q_rd_data)
    );

    thlt_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .q_rd_valid (q_rd_valid),
        .q_rd_ready (q_rd_ready),
        .q_rd_data  (q_rd_data),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_wait   (must_wait)
    );

    assign m_tdata = {7'd0, must_wait};

endmodule
